FILE: design/upsps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UPS poll sequencer package
// Shared types, codes and constants for the serial UPS query sequencer.
// ----------------------------------------------------------------------------
package upsps_pkg;

	localparam int REPLY_MAX_DEF  = 128;
	localparam int FAIL_LIMIT_DEF = 2;
	localparam int LEN_W          = 8;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = 2;
	localparam logic [2:0] BAUD_LAST = 3'd5;
	localparam logic [2:0] STEP_IDLE = 3'd5;
	localparam logic [15:0] TIMEOUT_RST = 16'd1500;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_B     = 8'h42;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	localparam logic [1:0] REG_POLL  = 2'd0;
	localparam logic [1:0] REG_ABAUD = 2'd1;
	localparam logic [1:0] REG_TMO   = 2'd2;

	localparam logic [2:0] KIND_QUERY = 3'd0;
	localparam logic [2:0] KIND_MODE  = 3'd1;
	localparam logic [2:0] KIND_FULL  = 3'd2;
	localparam logic [2:0] KIND_FAIL  = 3'd3;
	localparam logic [2:0] KIND_BAUD  = 3'd4;

	localparam logic [2:0] Q_MODE   = 3'd0;
	localparam logic [2:0] Q_STATUS = 3'd1;
	localparam logic [2:0] Q_BATT   = 3'd2;
	localparam logic [2:0] Q_WARN   = 3'd3;
	localparam logic [2:0] Q_OUTLET = 3'd4;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] query;
		logic [7:0] mode_code;
		logic       on_battery;
		logic       warning;
		logic       outlet_on;
		logic       outlet_known;
		logic       status_ok;
		logic       battery_ok;
		logic       publish;
		logic [2:0] baud_choice;
		logic       last;
	} evt_t;

	// words handed from the core to the output queue in the same cycle
	typedef struct packed {
		logic [1:0] n;
		evt_t       w0;
		evt_t       w1;
	} push_t;

	// expected tail of a "(NAK" reply, by byte position
	function automatic logic [7:0] nak_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd1:    ch = 8'h4E;
			2'd2:    ch = 8'h41;
			2'd3:    ch = 8'h4B;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: design/upsps_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UPS poll sequencer core
// Holds the round state and computes state update and result words per item.
// ----------------------------------------------------------------------------
module upsps_core
	import upsps_pkg::*;
#(
	parameter int REPLY_MAX  = REPLY_MAX_DEF,
	parameter int FAIL_LIMIT = FAIL_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        take,
	input  wire cmd_t        cmd,
	output push_t            push
);

	logic [15:0] poll_iv_q, tmo_q;
	logic        abaud_q;

	logic [31:0] now_q, step_start_q, last_poll_q;
	logic        busy_q, monly_q;
	logic [2:0]  step_q;
	logic [LEN_W-1:0] len_q;
	logic        open_q, nak_q, inf_q, one_q;
	logic [7:0]  second_q;
	logic [3:0]  cnt_q;
	logic        f_mode_q, f_stat_q, f_batt_q, f_warn_q, f_on_q, f_kn_q;
	logic [7:0]  mode_q, pub_q;
	logic [2:0]  bidx_q, fails_q;
	logic        lock_q;

	logic [31:0] now_n, step_start_n, last_poll_n;
	logic        busy_n, monly_n;
	logic [2:0]  step_n;
	logic [LEN_W-1:0] len_n;
	logic        open_n, nak_n, inf_n, one_n;
	logic [7:0]  second_n;
	logic [3:0]  cnt_n;
	logic        f_mode_n, f_stat_n, f_batt_n, f_warn_n, f_on_n, f_kn_n;
	logic [7:0]  mode_n, pub_n;
	logic [2:0]  bidx_n, fails_n;
	logic        lock_n;

	logic        do_adv, do_start, do_finish;
	logic [2:0]  tgt;
	logic [3:0]  fails_v;
	logic [7:0]  c;
	push_t       p;

	assign c = cmd.rx_byte;

	always_comb begin
		now_n = now_q; step_start_n = step_start_q; last_poll_n = last_poll_q;
		busy_n = busy_q; monly_n = monly_q; step_n = step_q; len_n = len_q;
		open_n = open_q; nak_n = nak_q; inf_n = inf_q; one_n = one_q;
		second_n = second_q; cnt_n = cnt_q;
		f_mode_n = f_mode_q; f_stat_n = f_stat_q; f_batt_n = f_batt_q;
		f_warn_n = f_warn_q; f_on_n = f_on_q; f_kn_n = f_kn_q;
		mode_n = mode_q; pub_n = pub_q;
		bidx_n = bidx_q; fails_n = fails_q; lock_n = lock_q;
		do_adv = 1'b0; do_start = 1'b0; do_finish = 1'b0; tgt = Q_MODE;
		fails_v = '0;
		p = '0;

		case (cmd.command)
			CMD_TICK: begin
				now_n = now_q + 32'd1;
				if (!busy_q) begin
					if (poll_iv_q != 16'd0 &&
					    (now_n - last_poll_q) >= {16'd0, poll_iv_q}) begin
						last_poll_n = now_n;
						busy_n = 1'b1;
						monly_n = 1'b1;
						f_mode_n = 1'b0;
						do_start = 1'b1;
					end
				end else if ((now_n - step_start_q) > {16'd0, tmo_q}) begin
					do_adv = 1'b1;
				end
			end
			CMD_BYTE: begin
				if (busy_q && c != CH_LF) begin
					if (c == CH_CR) begin
						// decode the finished reply
						if (len_q != '0 && open_q) begin
							if (abaud_q) lock_n = 1'b1;
							if (!(len_q >= LEN_W'(4) && nak_q)) begin
								case (step_q)
									Q_MODE: begin
										mode_n = second_q;
										f_mode_n = 1'b1;
									end
									Q_STATUS: if (cnt_q >= 4'd12) f_stat_n = 1'b1;
									Q_BATT:   if (cnt_q >= 4'd5) f_batt_n = 1'b1;
									Q_WARN:   if (one_q) f_warn_n = 1'b1;
									Q_OUTLET: begin
										if (second_q == CH_ONE) begin
											f_on_n = 1'b1; f_kn_n = 1'b1;
										end else if (second_q == CH_ZERO) begin
											f_on_n = 1'b0; f_kn_n = 1'b1;
										end
									end
									default: ;
								endcase
							end
						end
						do_adv = 1'b1;
					end else if (len_q < LEN_W'(REPLY_MAX - 1)) begin
						if (len_q == '0) begin
							if (c == CH_OPEN) begin
								open_n = 1'b1; nak_n = 1'b1;
							end
						end else begin
							if (len_q < LEN_W'(4) && c != nak_char(len_q[1:0]))
								nak_n = 1'b0;
							if (len_q == LEN_W'(1)) second_n = c;
							if (c == CH_SPACE) begin
								inf_n = 1'b0;
							end else begin
								if (!inf_q && cnt_q != 4'd15) cnt_n = cnt_q + 4'd1;
								inf_n = 1'b1;
							end
							if (c == CH_ONE) one_n = 1'b1;
						end
						len_n = len_q + LEN_W'(1);
					end
				end
			end
			CMD_START: begin
				if (!busy_q) begin
					busy_n = 1'b1;
					monly_n = 1'b0;
					last_poll_n = now_q;
					f_mode_n = 1'b0; f_stat_n = 1'b0; f_batt_n = 1'b0;
					f_warn_n = 1'b0; f_kn_n = 1'b0;
					do_start = 1'b1;
				end
			end
			default: ;
		endcase

		if (do_adv) begin
			if (monly_q || step_q >= Q_OUTLET) begin
				do_finish = 1'b1;
			end else begin
				do_start = 1'b1;
				tgt = step_q + 3'd1;
			end
		end

		if (do_start) begin
			step_n = tgt;
			len_n = '0;
			open_n = 1'b0; nak_n = 1'b0; inf_n = 1'b0; one_n = 1'b0;
			second_n = '0; cnt_n = '0;
			step_start_n = now_n;
			p.n = 2'd1;
			p.w0.kind = KIND_QUERY;
			p.w0.query = tgt;
			p.w0.baud_choice = bidx_n;
		end

		if (do_finish) begin
			p.n = 2'd1;
			if (monly_q) begin
				p.w0.kind = KIND_MODE;
				p.w0.mode_code = mode_n;
				p.w0.on_battery = (mode_n == CH_B);
				p.w0.baud_choice = bidx_n;
				if (f_mode_n && mode_n != pub_q) begin
					pub_n = mode_n;
					p.w0.publish = 1'b1;
				end
			end else if (!f_stat_n && !f_batt_n) begin
				p.w0.kind = KIND_FAIL;
				p.w0.baud_choice = bidx_n;
				if (abaud_q && !lock_n) begin
					fails_v = {1'b0, fails_n} + 4'd1;
					if (fails_v >= 4'(FAIL_LIMIT)) begin
						bidx_n = (bidx_n == BAUD_LAST) ? 3'd0 : bidx_n + 3'd1;
						lock_n = 1'b0;
						fails_n = '0;
						p.n = 2'd2;
						p.w1.kind = KIND_BAUD;
						p.w1.baud_choice = bidx_n;
					end else begin
						fails_n = fails_v[2:0];
					end
				end
			end else begin
				fails_n = '0;
				p.w0.kind = KIND_FULL;
				p.w0.mode_code = mode_n;
				p.w0.on_battery = (mode_n == CH_B);
				p.w0.warning = f_warn_n;
				p.w0.outlet_known = f_kn_n;
				p.w0.outlet_on = f_kn_n & f_on_n;
				p.w0.status_ok = f_stat_n;
				p.w0.battery_ok = f_batt_n;
				p.w0.baud_choice = bidx_n;
				pub_n = mode_n;
			end
			busy_n = 1'b0;
			monly_n = 1'b0;
			step_n = STEP_IDLE;
		end

		// flag the final word of this item
		if (p.n == 2'd1) p.w0.last = 1'b1;
		else if (p.n == 2'd2) p.w1.last = 1'b1;

		if (!take) p.n = 2'd0;
	end

	assign push = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_iv_q <= '0;
			abaud_q <= 1'b0;
			tmo_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL:  poll_iv_q <= cfg_data;
				REG_ABAUD: abaud_q <= cfg_data[0];
				REG_TMO:   tmo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0; step_start_q <= '0; last_poll_q <= '0;
			busy_q <= 1'b0; monly_q <= 1'b0; step_q <= STEP_IDLE; len_q <= '0;
			open_q <= 1'b0; nak_q <= 1'b0; inf_q <= 1'b0; one_q <= 1'b0;
			second_q <= '0; cnt_q <= '0;
			f_mode_q <= 1'b0; f_stat_q <= 1'b0; f_batt_q <= 1'b0;
			f_warn_q <= 1'b0; f_on_q <= 1'b0; f_kn_q <= 1'b0;
			mode_q <= '0; pub_q <= '0;
			bidx_q <= '0; fails_q <= '0; lock_q <= 1'b0;
		end else if (take) begin
			now_q <= now_n; step_start_q <= step_start_n; last_poll_q <= last_poll_n;
			busy_q <= busy_n; monly_q <= monly_n; step_q <= step_n; len_q <= len_n;
			open_q <= open_n; nak_q <= nak_n; inf_q <= inf_n; one_q <= one_n;
			second_q <= second_n; cnt_q <= cnt_n;
			f_mode_q <= f_mode_n; f_stat_q <= f_stat_n; f_batt_q <= f_batt_n;
			f_warn_q <= f_warn_n; f_on_q <= f_on_n; f_kn_q <= f_kn_n;
			mode_q <= mode_n; pub_q <= pub_n;
			bidx_q <= bidx_n; fails_q <= fails_n; lock_q <= lock_n;
		end
	end

endmodule
`default_nettype wire

FILE: design/upsps_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UPS poll sequencer result queue
// Small register queue taking up to two words a cycle, draining one.
// ----------------------------------------------------------------------------
module upsps_fifo
	import upsps_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       evt_valid,
	input  wire logic  evt_ready,
	output evt_t       evt
);

	evt_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_AW:0]     count_q;
	logic                 pop;

	assign evt_valid = (count_q != '0);
	assign pop       = evt_valid & evt_ready;
	assign evt       = mem_q[rd_q];
	// hold off input unless two words fit
	assign room      = (count_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q] <= push.w0;
		if (push.n == 2'd2) mem_q[wr_q + FIFO_AW'(1)] <= push.w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + FIFO_AW'(push.n);
			if (pop) rd_q <= rd_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW+1)'(push.n) - (FIFO_AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: design/ups_poll_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UPS poll sequencer
// Query-round sequencer and reply decoder for a serial UPS link.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (valid/ready) carries one word per ms tick, received byte or
//   round-start request. evt channel (valid/ready) carries the resulting
//   words: query requests, mode/full/failed round reports, baud switches.
//   An input word yields zero, one or two result words; the final one has
//   last set.
//   Results are written into the result queue when the input word is taken.
//   Throughput: one input word per cycle while cmd_ready is high, with the
//   round state updated as each word is taken; cmd_ready drops while the
//   four-entry result queue has fewer than two free slots.
//   Receiver stall: results wait in the queue; input is held off once it
//   cannot take two more words.
//   Reset: round idle, timeout 1500 ms, mode polls and auto baud off, baud
//   index 0. Config writes (cfg_we, cfg_index, cfg_data) are registered.
// ----------------------------------------------------------------------------
module ups_poll_sequencer
	import upsps_pkg::*;
#(
	parameter int REPLY_MAX  = REPLY_MAX_DEF,
	parameter int FAIL_LIMIT = FAIL_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  wire cmd_t        cmd,
	output logic             evt_valid,
	input  wire logic        evt_ready,
	output evt_t             evt
);

	push_t push;
	logic  room;

	assign cmd_ready = room;

	upsps_core #(
		.REPLY_MAX  (REPLY_MAX),
		.FAIL_LIMIT (FAIL_LIMIT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (cmd_valid & room),
		.cmd       (cmd),
		.push      (push)
	);

	upsps_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

endmodule
`default_nettype wire
